[hdl/xee_pkg.sv]
// Package for the XML entity escaper: entity codes, lengths and entity text.
// Used by xee_emit and xml_entity_escaper_core; depends on nothing else.
package xee_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned IdxW   = 3;   // enough for a 6-byte entity

  localparam logic [CountW-1:0] CapReset = 16'd256;

  // Entity codes; ENT_NONE is a plain byte or the terminator
  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_AMP,
    ENT_QUOT,
    ENT_APOS,
    ENT_LT,
    ENT_GT
  } ent_t;

  // Entity text, first character in the top byte, zero padded at the low end
  localparam logic [47:0] EntAmpStr  = {"&amp;", 8'h00};
  localparam logic [47:0] EntQuotStr = "&quot;";
  localparam logic [47:0] EntAposStr = "&apos;";
  localparam logic [47:0] EntLtStr   = {"&lt;", 16'h0000};
  localparam logic [47:0] EntGtStr   = {"&gt;", 16'h0000};

  // One work item handed from admission to the emitter
  typedef struct packed {
    logic [7:0]      byte_val;
    ent_t            ent;
    logic [IdxW-1:0] len;
    logic            str_end;
    logic            status;
  } emit_req_t;

  // Classify one source byte
  function automatic ent_t ent_of(input logic [7:0] b);
    ent_t e;
    e = ENT_NONE;
    case (b)
      8'h26:   e = ENT_AMP;   // ampersand
      8'h22:   e = ENT_QUOT;  // double quote
      8'h27:   e = ENT_APOS;  // apostrophe
      8'h3C:   e = ENT_LT;
      8'h3E:   e = ENT_GT;
      default: e = ENT_NONE;
    endcase
    return e;
  endfunction

  // Number of result bytes for a code (plain byte or terminator: one)
  function automatic logic [IdxW-1:0] ent_len(input ent_t e);
    logic [IdxW-1:0] l;
    l = 3'd1;
    unique case (e)
      ENT_AMP:  l = 3'd5;
      ENT_QUOT: l = 3'd6;
      ENT_APOS: l = 3'd6;
      ENT_LT:   l = 3'd4;
      ENT_GT:   l = 3'd4;
      default:  l = 3'd1;
    endcase
    return l;
  endfunction

  // Character at position idx of an entity
  function automatic logic [7:0] ent_char(input ent_t e, input logic [IdxW-1:0] idx);
    logic [47:0]     str;
    logic [IdxW-1:0] sel;
    str = '0;
    sel = 3'd5 - idx;
    unique case (e)
      ENT_AMP:  str = EntAmpStr;
      ENT_QUOT: str = EntQuotStr;
      ENT_APOS: str = EntAposStr;
      ENT_LT:   str = EntLtStr;
      ENT_GT:   str = EntGtStr;
      default:  str = '0;
    endcase
    return str[{sel, 3'b000} +: 8];
  endfunction

endpackage

[hdl/xee_emit.sv]
// Emitter of the XML entity escaper: holds one admitted item and plays out
// its result bytes into the output register. Depends on xee_pkg.
module xee_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  xee_pkg::emit_req_t req_i,
  output logic              ready_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_string_end,
  output logic              out_status
);
  import xee_pkg::*;

  // Work stage
  logic              a_valid_r;
  emit_req_t         a_req_r;
  logic [IdxW-1:0]   a_idx_r;

  // Output register
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_end_r;
  logic              out_status_r;

  logic              out_load;
  logic              cur_last;
  logic              a_done;
  logic [7:0]        cur_byte;

  // Current result of the work stage
  always_comb begin
    out_load = !out_valid_r || out_ready;
    cur_last = (a_idx_r == (a_req_r.len - 3'd1));
    a_done   = a_valid_r && out_load && cur_last;
    ready_o  = !a_valid_r || a_done;
    cur_byte = (a_req_r.ent == ENT_NONE) ? a_req_r.byte_val
                                         : ent_char(a_req_r.ent, a_idx_r);
  end

  // Work stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (load_i) begin
      a_valid_r <= 1'b1;
    end else if (a_done) begin
      a_valid_r <= 1'b0;
    end
  end

  // Work stage payload and position
  always_ff @(posedge clk) begin
    if (load_i) begin
      a_req_r <= req_i;
      a_idx_r <= '0;
    end else if (a_valid_r && out_load && !cur_last) begin
      a_idx_r <= a_idx_r + 3'd1;
    end
  end

  // Output register; loads whenever empty or the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && a_valid_r) begin
      out_byte_r   <= cur_byte;
      out_last_r   <= cur_last;
      out_end_r    <= a_req_r.str_end;
      out_status_r <= a_req_r.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_last_r;
  assign out_string_end = out_end_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  // Position never runs past the item's length
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (a_idx_r < a_req_r.len))
    else $error("emit position beyond item length");

  // The terminator is a single zero byte that closes its item
  term_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_last_r && out_byte_r == 8'h00))
    else $error("terminator result malformed");

  // A new item is only loaded when the stage is free or finishing
  no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> (!a_valid_r || a_done))
    else $error("work stage overwritten");
`endif

endmodule

[hdl/xml_entity_escaper_core.sv]
// XML entity escaper, top level: admission, count and failure state.
// A source byte passes the work stage and then the output register before it is sent.
// Throughput: one byte per cycle for plain bytes while out_ready holds; an entity
// holds the emitter until its last byte enters the single output register.
// Reset (rst_n, synchronous): capacity 256, count and failure cleared.
// Depends on xee_pkg and xee_emit.
module xml_entity_escaper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_status
);
  import xee_pkg::*;

  logic [CountW-1:0] cap_r;
  logic [CountW-1:0] out_count_r;
  logic [CountW-1:0] out_count_nxt;
  logic              failed_r;
  logic              failed_nxt;

  logic              emit_ready;
  logic              in_xfer;
  logic              load;
  emit_req_t         req;
  ent_t              ent;
  logic [IdxW-1:0]   len;
  logic [CountW-1:0] cap_eff;
  logic [CountW:0]   sum;
  logic              fits;
  logic              is_term;

  // Admission decision for the byte on the input port
  always_comb begin
    in_ready      = emit_ready;
    in_xfer       = in_valid && in_ready;
    ent           = ent_of(in_byte);
    len           = ent_len(ent);
    cap_eff       = (cap_r == '0) ? 16'd1 : cap_r;
    sum           = {1'b0, out_count_r} + {{(CountW+1-IdxW){1'b0}}, len};
    fits          = sum < {1'b0, cap_eff};
    is_term       = (in_byte == 8'h00);
    out_count_nxt = out_count_r;
    failed_nxt    = failed_r;
    load          = 1'b0;
    if (in_xfer) begin
      if (is_term) begin
        load          = 1'b1;
        out_count_nxt = '0;
        failed_nxt    = 1'b0;
      end else if (!failed_r) begin
        if (fits) begin
          load          = 1'b1;
          out_count_nxt = sum[CountW-1:0];
        end else if (ent != ENT_NONE) begin
          failed_nxt    = 1'b1;
        end
      end
    end
    req.byte_val = in_byte;
    req.ent      = ent;
    req.len      = len;
    req.str_end  = is_term;
    req.status   = is_term && failed_r;
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Per-string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r <= '0;
      failed_r    <= 1'b0;
    end else begin
      out_count_r <= out_count_nxt;
      failed_r    <= failed_nxt;
    end
  end

  xee_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (load),
    .req_i          (req),
    .ready_o        (emit_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_status     (out_status)
  );

`ifndef SYNTHESIS
  // After failure only the terminator produces output
  fail_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !req.str_end) |-> !failed_r)
    else $error("output admitted after failure");

  // Terminator clears the per-string state
  term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_byte == 8'h00) |=> (out_count_r == '0 && !failed_r))
    else $error("terminator did not clear state");

  // Count moves only on admitted output or the terminator
  count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(out_count_r))
    else $error("count changed without output");
`endif

endmodule
